/* hw/rtl/huffman_tree_walk_decoder_unit_defines.svh */
// assertion macros used by the checker of the huffman tree-walk decoder
`ifndef HUFFMAN_TREE_WALK_DECODER_UNIT_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HTWD_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("htwd same-cycle check failed");

// next-cycle implication, checked outside reset
`define HTWD_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("htwd next-cycle check failed");

`endif

/* hw/rtl/htwd_pkg.sv */
// types and constants of the huffman tree-walk decoder
package htwd_pkg;

  localparam int unsigned IDX_W       = 9;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CNT_W       = 4;   // holds 0..MAX_RESULTS
  localparam int unsigned SLOT_W      = 3;   // indexes MAX_RESULTS slots
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned BITCNT_W    = 4;   // holds 0..BITS_PER_BYTE
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [BYTE_W-1:0]   BIT_MSB        = 8'h80;
  localparam logic [BITCNT_W-1:0] BITS_PER_BYTE  = 4'd8;

  // input op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // register word index, taken from paddr[2]
  localparam logic REG_SYMBOL_TOTAL = 1'b0;

  // one node table entry
  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  localparam int unsigned NODE_W = $bits(node_t);

  // controller to datapath
  typedef struct packed {
    logic load;        // write one node
    logic byte_start;  // capture a byte and begin the walk
    logic byte_done;   // byte after completion or with nothing to decode: one status result
    logic eval;        // ram data holds a child entry to evaluate
    logic issue;       // read the child chosen by the next code bit
    logic drain;       // send one buffered result
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic exhausted;   // no symbols left to decode
    logic stop;        // last symbol reached in this evaluation
    logic drain_last;  // result being sent is the last of the byte
  } dp_stat_t;

endpackage

/* hw/rtl/htwd_ram.sv */
// generic single-port-write, registered-read ram
module htwd_ram #(
  parameter int unsigned WIDTH = 27,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/htwd_ctrl.sv */
// sequencer of the tree walk: accept, per-bit walk, result drain
module htwd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                op,
  input  htwd_pkg::dp_stat_t  stat,
  output htwd_pkg::ctl_cmd_t  cmd,
  output logic                busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN
  } state_t;

  state_t                          state;
  logic [htwd_pkg::BITCNT_W-1:0]   bit_cnt;

  assign busy = (state != S_IDLE);

  // commands from state and bit position
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (op == htwd_pkg::OP_LOAD) begin
            cmd.load = 1'b1;
          end else if (stat.exhausted) begin
            cmd.byte_done = 1'b1;
          end else begin
            cmd.byte_start = 1'b1;
          end
        end
      end
      S_WALK: begin
        cmd.eval  = (bit_cnt != '0);
        cmd.issue = (bit_cnt != htwd_pkg::BITS_PER_BYTE);
      end
      S_DRAIN: begin
        cmd.drain = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  // state and bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bit_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          bit_cnt <= '0;
          if (cmd.byte_start) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (stat.stop || bit_cnt == htwd_pkg::BITS_PER_BYTE) begin
            state <= S_DRAIN;
          end
          bit_cnt <= bit_cnt + 1'b1;
        end
        S_DRAIN: begin
          if (stat.drain_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/htwd_datapath.sv */
// node table, walk registers, result buffer, config register and result outputs
module htwd_datapath #(
  parameter int unsigned NODE_DEPTH = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  input  htwd_pkg::ctl_cmd_t                cmd,
  output htwd_pkg::dp_stat_t                stat,
  // payload in
  input  logic [htwd_pkg::IDX_W-1:0]        node_index,
  input  logic                              node_is_leaf,
  input  logic [htwd_pkg::SYM_W-1:0]        node_symbol,
  input  logic [htwd_pkg::IDX_W-1:0]        left_index,
  input  logic [htwd_pkg::IDX_W-1:0]        right_index,
  input  logic [htwd_pkg::BYTE_W-1:0]       compressed_byte,
  input  logic                              stream_end,
  // config write and read
  input  logic                              cfg_we,
  input  logic [htwd_pkg::PADDR_W-1:0]      paddr,
  input  logic [htwd_pkg::PDATA_W-1:0]      pwdata,
  output logic [htwd_pkg::PDATA_W-1:0]      prdata,
  // results
  output logic                              strobe,
  output logic [htwd_pkg::SYM_W-1:0]        decoded_symbol,
  output logic                              symbol_valid,
  output logic                              last_of_run,
  output logic                              all_decoded,
  output logic                              stream_short
);

  localparam int unsigned AW = $clog2(NODE_DEPTH);

  // register and walk state
  logic [htwd_pkg::PDATA_W-1:0]  symbol_total;
  logic [htwd_pkg::PDATA_W-1:0]  symbols_left;
  logic                          done_flag;
  logic [htwd_pkg::IDX_W-1:0]    current_node;
  htwd_pkg::node_t               root_entry;
  logic [htwd_pkg::BYTE_W-1:0]   code_bits;
  logic                          end_of_stream;
  logic [htwd_pkg::IDX_W-1:0]    read_idx;
  logic                          read_oor;
  logic [htwd_pkg::CNT_W-1:0]    sym_cnt;
  logic [htwd_pkg::SLOT_W-1:0]   drain_idx;
  logic [htwd_pkg::SYM_W-1:0]    sym_buf [htwd_pkg::MAX_RESULTS];

  // node table port signals
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  htwd_pkg::node_t               ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [htwd_pkg::NODE_W-1:0]   ram_rdata;

  // walk signals
  htwd_pkg::node_t               child;
  htwd_pkg::node_t               entry;
  logic                          hit_leaf;
  logic [htwd_pkg::IDX_W-1:0]    sel_idx;
  logic [htwd_pkg::IDX_W-1:0]    next_idx;
  logic                          reg_sel;
  logic                          short_flag;

  assign reg_sel = (paddr[2] == htwd_pkg::REG_SYMBOL_TOTAL);
  assign prdata  = reg_sel ? symbol_total : '0;

  // node writes land only inside the table
  assign ram_we    = cmd.load && (32'(node_index) < 32'(NODE_DEPTH));
  assign ram_waddr = AW'(node_index);
  assign ram_wdata = '{leaf: node_is_leaf, symbol: node_symbol,
                       left: left_index, right: right_index};

  htwd_ram #(
    .WIDTH (htwd_pkg::NODE_W),
    .DEPTH (NODE_DEPTH)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // an index beyond the table reads as an all-zero inner node
  assign child    = read_oor ? '0 : htwd_pkg::node_t'(ram_rdata);
  assign hit_leaf = cmd.eval && child.leaf;
  assign entry    = hit_leaf ? root_entry : child;
  assign next_idx = ((code_bits & htwd_pkg::BIT_MSB) != '0) ? entry.right : entry.left;

  // read the chosen child while walking, else the current node
  assign sel_idx   = cmd.issue ? next_idx : current_node;
  assign ram_raddr = AW'(sel_idx);

  assign stat.exhausted  = done_flag || (symbols_left == '0);
  assign stat.stop       = hit_leaf && (symbols_left == 32'd1);
  assign stat.drain_last = (sym_cnt == '0) ||
                           ({1'b0, drain_idx} == sym_cnt - 1'b1);

  assign short_flag = end_of_stream && !done_flag;

  // read index pipeline, root copy, code bits and result buffer
  always_ff @(posedge clk) begin
    read_idx <= sel_idx;
    read_oor <= (32'(sel_idx) >= 32'(NODE_DEPTH));
    if (cmd.load && node_index == '0) begin
      root_entry <= ram_wdata;
    end
    if (cmd.byte_start) begin
      code_bits     <= compressed_byte;
      end_of_stream <= stream_end;
    end else if (cmd.issue) begin
      code_bits <= code_bits << 1;
    end
    if (hit_leaf) begin
      sym_buf[sym_cnt[htwd_pkg::SLOT_W-1:0]] <= child.symbol;
    end
  end

  // walk control state
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_total <= '0;
      symbols_left <= '0;
      done_flag    <= 1'b0;
      current_node <= '0;
      sym_cnt      <= '0;
      drain_idx    <= '0;
    end else begin
      if (cfg_we && reg_sel) begin
        symbol_total <= pwdata;
        symbols_left <= pwdata;
        done_flag    <= 1'b0;
        current_node <= '0;
      end else begin
        if (cmd.byte_done) begin
          done_flag <= 1'b1;
        end
        if (cmd.eval) begin
          current_node <= hit_leaf ? '0 : read_idx;
        end
        if (hit_leaf) begin
          symbols_left <= symbols_left - 1'b1;
          if (symbols_left == 32'd1) begin
            done_flag <= 1'b1;
          end
        end
      end
      if (cmd.byte_start) begin
        sym_cnt   <= '0;
        drain_idx <= '0;
      end else begin
        if (hit_leaf) begin
          sym_cnt <= sym_cnt + 1'b1;
        end
        if (cmd.drain) begin
          drain_idx <= drain_idx + 1'b1;
        end
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.drain || cmd.byte_done;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.byte_done) begin
      decoded_symbol <= '0;
      symbol_valid   <= 1'b0;
      last_of_run    <= 1'b1;
      all_decoded    <= 1'b1;
      stream_short   <= 1'b0;
    end else if (cmd.drain) begin
      if (sym_cnt == '0) begin
        decoded_symbol <= '0;
        symbol_valid   <= 1'b0;
        last_of_run    <= 1'b1;
        all_decoded    <= 1'b0;
      end else begin
        decoded_symbol <= sym_buf[drain_idx];
        symbol_valid   <= 1'b1;
        last_of_run    <= stat.drain_last;
        all_decoded    <= stat.drain_last && done_flag;
      end
      stream_short <= short_flag;
    end
  end

endmodule

/* hw/rtl/huffman_tree_walk_decoder_unit.sv */
// top level of the huffman tree-walk decoder
//
//  channel   | handshake                        | payload
//  ----------+----------------------------------+---------------------------------------
//  input     | start & !busy                    | op, node_index, node_is_leaf,
//            |                                  | node_symbol, left_index, right_index,
//            |                                  | compressed_byte, stream_end
//  result    | strobe, one cycle, no stall      | decoded_symbol, symbol_valid,
//            |                                  | last_of_run, all_decoded, stream_short
//  config    | psel & penable & pwrite & pready | paddr, pwdata, prdata (symbol_total)
//
// a node load is absorbed while busy stays low
// a byte walks one code bit per node table read, then evaluates the last child (fewer
// bits when the last symbol stops the walk), then drains one result a cycle
// a byte after completion or with nothing to decode gives its one status result the next cycle, busy low
// rst is synchronous; the node table keeps its contents and must be loaded
// results cannot be stalled: each transfer lasts exactly one strobe cycle
module huffman_tree_walk_decoder_unit #(
  parameter int unsigned NODE_DEPTH = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              start,
  output logic                              busy,
  input  logic                              op,
  input  logic [htwd_pkg::IDX_W-1:0]        node_index,
  input  logic                              node_is_leaf,
  input  logic [htwd_pkg::SYM_W-1:0]        node_symbol,
  input  logic [htwd_pkg::IDX_W-1:0]        left_index,
  input  logic [htwd_pkg::IDX_W-1:0]        right_index,
  input  logic [htwd_pkg::BYTE_W-1:0]       compressed_byte,
  input  logic                              stream_end,
  // results
  output logic                              strobe,
  output logic [htwd_pkg::SYM_W-1:0]        decoded_symbol,
  output logic                              symbol_valid,
  output logic                              last_of_run,
  output logic                              all_decoded,
  output logic                              stream_short,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [htwd_pkg::PADDR_W-1:0]      paddr,
  input  logic [htwd_pkg::PDATA_W-1:0]      pwdata,
  output logic [htwd_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  htwd_pkg::ctl_cmd_t cmd;
  htwd_pkg::dp_stat_t stat;
  logic               cfg_we;

  // zero wait-state register access
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  htwd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  htwd_datapath #(
    .NODE_DEPTH (NODE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .node_index      (node_index),
    .node_is_leaf    (node_is_leaf),
    .node_symbol     (node_symbol),
    .left_index      (left_index),
    .right_index     (right_index),
    .compressed_byte (compressed_byte),
    .stream_end      (stream_end),
    .cfg_we          (cfg_we),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .strobe          (strobe),
    .decoded_symbol  (decoded_symbol),
    .symbol_valid    (symbol_valid),
    .last_of_run     (last_of_run),
    .all_decoded     (all_decoded),
    .stream_short    (stream_short)
  );

endmodule

/* hw/rtl/htwd_checker.sv */
// port-level checks of the huffman tree-walk decoder and their bind
`include "huffman_tree_walk_decoder_unit_defines.svh"

module htwd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        op,
  input logic                        strobe,
  input logic [htwd_pkg::SYM_W-1:0]  decoded_symbol,
  input logic                        symbol_valid,
  input logic                        last_of_run,
  input logic                        all_decoded,
  input logic                        stream_short
);

  // completion and a short stream exclude each other
  `HTWD_ASSERT_NOW(a_done_not_short, clk, rst, strobe && all_decoded, !stream_short)

  // a status-only result carries symbol zero
  `HTWD_ASSERT_NOW(a_status_zero, clk, rst, strobe && !symbol_valid, decoded_symbol == '0)

  // results of one byte come in consecutive cycles
  `HTWD_ASSERT_NEXT(a_run_contiguous, clk, rst, strobe && !last_of_run, strobe)

  // an accepted byte is either being walked or answered at once
  `HTWD_ASSERT_NEXT(a_byte_response, clk, rst,
    start && !busy && op == htwd_pkg::OP_BYTE, busy || strobe)

  // a node load is absorbed without any result
  `HTWD_ASSERT_NEXT(a_load_silent, clk, rst,
    start && !busy && op == htwd_pkg::OP_LOAD, !busy && !strobe)

endmodule

bind huffman_tree_walk_decoder_unit htwd_checker u_htwd_checker (.*);

/* dv/tb_huffman_tree_walk_decoder_unit.sv */
// testbench of the huffman tree-walk decoder: node loads, byte walks, symbol_total settings
`timescale 1ns / 1ps

module tb_huffman_tree_walk_decoder_unit;

  localparam int unsigned IDX_W = htwd_pkg::IDX_W;
  localparam int unsigned SYM_W = htwd_pkg::SYM_W;
  localparam int unsigned BYTE_W = htwd_pkg::BYTE_W;
  localparam int unsigned PADDR_W = htwd_pkg::PADDR_W;
  localparam int unsigned PDATA_W = htwd_pkg::PDATA_W;
  localparam int unsigned TABLE_DEPTH = 512;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam logic [PADDR_W-1:0] SYMBOL_TOTAL_ADDR = {htwd_pkg::REG_SYMBOL_TOTAL, 2'b00};

  typedef struct {
    logic               op;
    logic [IDX_W-1:0]   node_index;
    logic               node_is_leaf;
    logic [SYM_W-1:0]   node_symbol;
    logic [IDX_W-1:0]   left_index;
    logic [IDX_W-1:0]   right_index;
    logic [BYTE_W-1:0]  compressed_byte;
    logic               stream_end;
  } cmd_t;

  typedef struct {
    logic [SYM_W-1:0] symbol;
    logic             valid;
    logic             last;
    logic             all_done;
    logic             short_stream;
  } symbol_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic op = htwd_pkg::OP_LOAD;
  logic [IDX_W-1:0] node_index = '0;
  logic node_is_leaf = 1'b0;
  logic [SYM_W-1:0] node_symbol = '0;
  logic [IDX_W-1:0] left_index = '0;
  logic [IDX_W-1:0] right_index = '0;
  logic [BYTE_W-1:0] compressed_byte = '0;
  logic stream_end = 1'b0;
  logic strobe;
  logic [SYM_W-1:0] decoded_symbol;
  logic symbol_valid;
  logic last_of_run;
  logic all_decoded;
  logic stream_short;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // pending commands and decoded symbols still owed by the block
  cmd_t        cmd_q[$];
  cmd_t        cur_cmd;
  symbol_res_t decoded_q[$];
  int          idle_pct = 0;
  int          errs = 0;

  // predictor copy of the decoder state
  htwd_pkg::node_t  node_mem [TABLE_DEPTH];
  logic [IDX_W-1:0] walk_node = '0;
  logic [31:0]      symbols_left_q = '0;
  logic             decode_done = 1'b0;

  // written entries as seen by the stimulus generator
  bit               gen_written [TABLE_DEPTH];
  int               gen_list[$];

  huffman_tree_walk_decoder_unit u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // apply one command: store a loaded node, or walk the tree and queue the symbols a byte yields
  task automatic decode_item(input cmd_t it);
    htwd_pkg::node_t  ent;
    htwd_pkg::node_t  child;
    logic [IDX_W-1:0] nxt;
    symbol_res_t      outs[$];
    symbol_res_t      r;
    int               b;
    if (it.op == htwd_pkg::OP_LOAD) begin
      node_mem[it.node_index] = {it.node_is_leaf, it.node_symbol, it.left_index,
                                 it.right_index};
      return;
    end
    // byte after completion or with nothing to decode
    if (decode_done || symbols_left_q == 0) begin
      decode_done = 1'b1;
      r = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0};
      decoded_q.push_back(r);
      return;
    end
    for (b = BYTE_W - 1; b >= 0 && !decode_done; b--) begin
      ent = node_mem[walk_node];
      nxt = it.compressed_byte[b] ? ent.right : ent.left;
      child = node_mem[nxt];
      if (child.leaf) begin
        symbols_left_q = symbols_left_q - 1;
        if (symbols_left_q == 0) decode_done = 1'b1;
        r = '{child.symbol, 1'b1, 1'b0, decode_done, 1'b0};
        outs.push_back(r);
        walk_node = '0;
      end else begin
        walk_node = nxt;
      end
    end
    // no leaf reached: one status-only result
    if (outs.size() == 0) begin
      r = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
      outs.push_back(r);
    end
    outs[outs.size()-1].last = 1'b1;
    foreach (outs[k]) begin
      outs[k].short_stream = it.stream_end && !decode_done;
      decoded_q.push_back(outs[k]);
    end
  endtask

  // driver: present the next command, hold it until the transfer
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) decode_item(cur_cmd);
      if (!start || !busy) begin
        if (cmd_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
          cur_cmd = cmd_q.pop_front();
          start <= 1'b1;
          op <= cur_cmd.op;
          node_index <= cur_cmd.node_index;
          node_is_leaf <= cur_cmd.node_is_leaf;
          node_symbol <= cur_cmd.node_symbol;
          left_index <= cur_cmd.left_index;
          right_index <= cur_cmd.right_index;
          compressed_byte <= cur_cmd.compressed_byte;
          stream_end <= cur_cmd.stream_end;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    symbol_res_t exp_res;
    if (!rst && strobe) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: decoded_symbol %0h", decoded_symbol);
        errs++;
      end else begin
        exp_res = decoded_q.pop_front();
        if (decoded_symbol !== exp_res.symbol) begin
          $error("decoded_symbol: expected %0h, got %0h", exp_res.symbol, decoded_symbol);
          errs++;
        end
        if (symbol_valid !== exp_res.valid) begin
          $error("symbol_valid: expected %0b, got %0b", exp_res.valid, symbol_valid);
          errs++;
        end
        if (last_of_run !== exp_res.last) begin
          $error("last_of_run: expected %0b, got %0b", exp_res.last, last_of_run);
          errs++;
        end
        if (all_decoded !== exp_res.all_done) begin
          $error("all_decoded: expected %0b, got %0b", exp_res.all_done, all_decoded);
          errs++;
        end
        if (stream_short !== exp_res.short_stream) begin
          $error("stream_short: expected %0b, got %0b", exp_res.short_stream, stream_short);
          errs++;
        end
      end
    end
  end

  // wait until every command is taken and every result has arrived
  task automatic wait_idle();
    @(negedge clk);
    while (cmd_q.size() != 0 || start || busy || decoded_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write symbol_total over the config port, then read it back
  task automatic write_total(input logic [31:0] v);
    wait_idle();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SYMBOL_TOTAL_ADDR;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    symbols_left_q = v;
    walk_node = '0;
    decode_done = 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== v) begin
      $error("symbol_total: expected %0h, got %0h", v, prdata);
      errs++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_load(input logic [IDX_W-1:0] idx, input logic leaf,
                           input logic [SYM_W-1:0] sym, input logic [IDX_W-1:0] l,
                           input logic [IDX_W-1:0] r);
    cmd_t c;
    c = '{htwd_pkg::OP_LOAD, idx, leaf, sym, l, r, BYTE_W'($urandom), 1'($urandom)};
    cmd_q.push_back(c);
    if (!gen_written[idx]) begin
      gen_written[idx] = 1'b1;
      gen_list.push_back(int'(idx));
    end
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] code, input logic fin);
    cmd_t c;
    c = '{htwd_pkg::OP_BYTE, IDX_W'($urandom), 1'($urandom), SYM_W'($urandom),
          IDX_W'($urandom), IDX_W'($urandom), code, fin};
    cmd_q.push_back(c);
  endtask

  // overwrite a loaded entry; children stay within loaded entries
  task automatic push_noise_load();
    push_load(IDX_W'(gen_list[$urandom_range(gen_list.size()-1, 0)]), 1'($urandom),
              SYM_W'($urandom), IDX_W'(gen_list[$urandom_range(gen_list.size()-1, 0)]),
              IDX_W'(gen_list[$urandom_range(gen_list.size()-1, 0)]));
  endtask

  // random full code tree with its root at entry 0, loaded in random order
  task automatic load_tree(input int leaves);
    int               kid_l[$];
    int               kid_r[$];
    int               open[$];
    int               order[$];
    bit               inner[$];
    logic [IDX_W-1:0] slot[$];
    bit               used [TABLE_DEPTH];
    logic [IDX_W-1:0] pick;
    int               p, k, j, n, tmp;
    inner.push_back(1'b0);
    kid_l.push_back(0);
    kid_r.push_back(0);
    open.push_back(0);
    do begin
      p = $urandom_range(open.size()-1, 0);
      k = open[p];
      open.delete(p);
      n = inner.size();
      inner[k] = 1'b1;
      kid_l[k] = n;
      kid_r[k] = n + 1;
      repeat (2) begin
        inner.push_back(1'b0);
        kid_l.push_back(0);
        kid_r.push_back(0);
      end
      open.push_back(n);
      open.push_back(n + 1);
    end while (open.size() < leaves);
    // place the nodes at distinct table entries
    used[0] = 1'b1;
    slot.push_back('0);
    for (k = 1; k < inner.size(); k++) begin
      do pick = IDX_W'($urandom_range(TABLE_DEPTH - 1, 1)); while (used[pick]);
      used[pick] = 1'b1;
      slot.push_back(pick);
    end
    for (k = 0; k < inner.size(); k++) order.push_back(k);
    for (k = order.size() - 1; k > 0; k--) begin
      j = $urandom_range(k, 0);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) begin
      k = order[i];
      if (inner[k])
        push_load(slot[k], 1'b0, SYM_W'($urandom), slot[kid_l[k]], slot[kid_r[k]]);
      else
        push_load(slot[k], 1'b1, SYM_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
    end
  endtask

  // small random graph with loops, leaves and the root possibly a leaf
  task automatic load_graph();
    logic [IDX_W-1:0] members[$];
    int               m;
    m = $urandom_range(8, 3);
    members.push_back('0);
    repeat (m - 1) members.push_back(IDX_W'($urandom_range(TABLE_DEPTH - 1, 1)));
    foreach (members[i])
      push_load(members[i], 1'($urandom), SYM_W'($urandom),
                members[$urandom_range(m - 1, 0)], members[$urandom_range(m - 1, 0)]);
  endtask

  // stimulus
  initial begin
    logic [31:0] total;
    int          nb;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: byte with nothing to decode straight out of reset
    push_byte(8'hA5, 1'b0);
    // never-completing run on a hand-built tree, full eight-symbol byte first
    write_total(32'hFFFF_FFFF);
    push_load(9'd0, 1'b0, 8'hFF, 9'd1, 9'd2);
    push_load(9'd1, 1'b1, 8'h00, 9'h1FF, 9'h1FF);
    push_load(9'd2, 1'b0, 8'h80, 9'd3, 9'd511);
    push_load(9'd3, 1'b1, 8'hFF, 9'd0, 9'd0);
    push_load(9'd511, 1'b0, 8'h80, 9'd0, 9'd0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hD0, 1'b1);
    push_byte(8'h80, 1'b0);
    // completion inside a byte, then a byte past completion at stream end
    write_total(32'd3);
    push_byte(8'h00, 1'b0);
    push_byte(8'h5A, 1'b1);
    // root as a leaf reached through its own child links
    write_total(32'd2);
    push_load(9'd0, 1'b1, 8'h5A, 9'd0, 9'd0);
    push_byte(8'h3C, 1'b1);
    push_byte(8'hC3, 1'b0);
    // zero symbols to decode
    write_total(32'd0);
    push_byte(8'hFF, 1'b1);

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: total = 32'hFFFF_FFFF;
        1: total = 32'd0;
        2: total = 32'd1;
        3: total = $urandom;
        default: total = $urandom_range(60, 4);
      endcase
      write_total(total);
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 88;
        2: idle_pct = 20;
        default: idle_pct = $urandom_range(60, 0);
      endcase
      if (ph == 5 || ph == 8) load_graph();
      else if (ph % 3 != 1) load_tree($urandom_range(12, 2));
      nb = $urandom_range(30, 15);
      for (int k = 0; k < nb; k++) begin
        if ($urandom_range(14, 0) == 0) push_noise_load();
        push_byte(BYTE_W'($urandom), k == nb - 1 || $urandom_range(9, 0) == 0);
        // hold the sender until the block has drained
        if (ph == 4 && k == nb / 2) wait_idle();
      end
    end

    wait_idle();
    if (errs == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/htwd_pkg.sv
hw/rtl/htwd_ram.sv
hw/rtl/htwd_ctrl.sv
hw/rtl/htwd_datapath.sv
hw/rtl/huffman_tree_walk_decoder_unit.sv
hw/rtl/htwd_checker.sv
dv/tb_huffman_tree_walk_decoder_unit.sv
